@@ rtl/rpn_stack_evaluator_macros.svh @@
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RPN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rpn_pkg.sv @@
`timescale 1ns / 1ps

package rpn_pkg;

	localparam int WORD_W = 32;
	localparam int DIV_CNT_W = 5;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
	localparam logic [1:0] STAT_DIVZERO   = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic shift_dn;
		logic shift_up;
	} cell_ctl_t;

endpackage

@@ rtl/rpn_stack_evaluator.sv @@
`timescale 1ns / 1ps

// RPN integer calculator, one ASCII character per input transfer. The operand
// stack is a row of STACK_DEPTH shift cells with the top entry in cell 0, so
// there is no memory and no clearing pass after reset. Digits, '+', '-', '*',
// '=' and ignored characters are handled as each is accepted. '/' with a
// valid nonzero divisor starts the radix-2 restoring divider, which runs 32
// iterations and then writes the quotient back. A result waits in an output
// register; further characters are still taken then, but '=' is held off
// until that register is free or is being emptied in the same cycle. Errors
// (underflow, overflow, divide by zero) are sticky and reported with value 0
// at the next '='.

module rpn_stack_evaluator
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic [1:0]  status
);

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic               state_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [1:0]         err_q;
	logic               out_valid_q;
	word_t              value_q;
	logic [1:0]         status_q;

	word_t     cell_data [STACK_DEPTH];
	cell_ctl_t cell_ctl  [STACK_DEPTH];

	logic  is_digit;
	logic  is_arith;
	logic  is_div;
	logic  is_eq;
	logic  accept;
	logic  has_two;
	logic  has_room;
	logic  push;
	logic  arith_wb;
	logic  div_start;
	logic  div_done;
	logic  write_back;
	word_t div_q;
	word_t arith_res;
	word_t wr_data;
	logic  [1:0] new_err;
	logic  set_err;

	always_comb begin
		is_digit = char_code inside {[CH_ZERO:CH_NINE]};
		is_arith = char_code inside {CH_PLUS, CH_MINUS, CH_STAR};
		is_div   = (char_code == CH_SLASH);
		is_eq    = (char_code == CH_EQ);
	end

	assign in_ready = (state_q == ST_IDLE) && (!is_eq || !out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign has_two  = (depth_q >= DEPTH_W'(2));
	assign has_room = (depth_q < DEPTH_W'(STACK_DEPTH));

	assign push       = accept && is_digit && has_room;
	assign arith_wb   = accept && is_arith && has_two;
	assign div_start  = accept && is_div && has_two && (cell_data[0] != '0);
	assign write_back = arith_wb || div_done;

	always_comb begin
		case (char_code)
			CH_PLUS:  arith_res = cell_data[1] + cell_data[0];
			CH_MINUS: arith_res = cell_data[1] - cell_data[0];
			default:  arith_res = word_t'(cell_data[1] * cell_data[0]);
		endcase
	end

	always_comb begin
		if (div_done) begin
			wr_data = div_q;
		end else if (push) begin
			wr_data = word_t'(char_code - CH_ZERO);
		end else begin
			wr_data = arith_res;
		end
	end

	always_comb begin
		set_err = 1'b0;
		new_err = STAT_OK;
		if (accept && is_digit && !has_room) begin
			set_err = 1'b1;
			new_err = STAT_OVERFLOW;
		end else if (accept && (is_arith || is_div) && !has_two) begin
			set_err = 1'b1;
			new_err = STAT_UNDERFLOW;
		end else if (accept && is_div && (cell_data[0] == '0)) begin
			set_err = 1'b1;
			new_err = STAT_DIVZERO;
		end
	end

	generate
		for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
			word_t prev_d;
			word_t next_d;
			if (i == 0) begin : g_top
				assign prev_d = wr_data;
				assign cell_ctl[i] = '{shift_dn: push || write_back, shift_up: 1'b0};
			end else begin : g_mid
				assign prev_d = cell_data[i-1];
				assign cell_ctl[i] = '{shift_dn: push, shift_up: write_back};
			end
			if (i == STACK_DEPTH - 1) begin : g_bot
				assign next_d = '0;
			end else begin : g_nxt
				assign next_d = cell_data[i+1];
			end
			rpn_cell u_cell (
				.clk       (clk),
				.ctl       (cell_ctl[i]),
				.prev_data (prev_d),
				.next_data (next_d),
				.data      (cell_data[i])
			);
		end
	endgenerate

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (cell_data[1]),
		.den      (cell_data[0]),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (div_start) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (accept && is_eq) begin
				depth_q <= '0;
				err_q   <= STAT_OK;
			end else begin
				if (push) begin
					depth_q <= depth_q + DEPTH_W'(1);
				end else if (write_back) begin
					depth_q <= depth_q - DEPTH_W'(1);
				end
				if (set_err && (err_q == STAT_OK)) begin
					err_q <= new_err;
				end
			end

			if (accept && is_eq) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_eq) begin
			if (err_q != STAT_OK) begin
				value_q  <= '0;
				status_q <= err_q;
			end else if (depth_q == '0) begin
				value_q  <= '0;
				status_q <= STAT_UNDERFLOW;
			end else begin
				value_q  <= cell_data[0];
				status_q <= STAT_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

`include "rpn_stack_evaluator_macros.svh"

	`RPN_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DEPTH_W'(STACK_DEPTH), "stack depth past capacity")
	`RPN_ASSERT_NOW(a_err_zero_value, out_valid && (status != STAT_OK), value == '0, "error result with nonzero value")
	`RPN_ASSERT_NOW(a_div_no_accept, state_q == ST_DIV, !in_ready, "input taken during division")
	`RPN_ASSERT_NEXT(a_eq_emits, accept && is_eq, out_valid && (depth_q == '0) && (err_q == STAT_OK), "equals did not emit and clear")

endmodule

@@ rtl/rpn_cell.sv @@
`timescale 1ns / 1ps

module rpn_cell
	import rpn_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  word_t     prev_data,
	input  word_t     next_data,
	output word_t     data
);

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_dn) begin
			data_q <= prev_data;
		end else if (ctl.shift_up) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

@@ rtl/rpn_div.sv @@
`timescale 1ns / 1ps

module rpn_div
	import rpn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t num,
	input  word_t den,
	output logic  done,
	output word_t quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	word_t                rem_q;
	word_t                quo_q;
	word_t                den_q;
	word_t                num_mag;
	word_t                den_mag;
	word_t                shifted;
	logic [WORD_W:0]      diff;

	assign num_mag = num[WORD_W-1] ? (~num + word_t'(1)) : num;
	assign den_mag = den[WORD_W-1] ? (~den + word_t'(1)) : den;
	assign shifted = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
	assign diff    = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == {DIV_CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den_mag;
			neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + word_t'(1)) : quo_q;

endmodule
